FILE: rtl/ecis_pkg.sv
// Shared types, constants and datapath command/status encodings for the
// earliest circle impact search block. No dependencies.
package ecis_pkg;

	localparam int MAX_CIRCLES_DEF = 64;
	localparam logic [31:0] MAX_TIME_RST = 32'h0001_0000;
	localparam int IDX_W = 6;
	localparam int MAG_W = 33;
	localparam int MW = 67;
	localparam int PW = 2 * MW;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic [30:0] radius;
		logic is_static;
	} circle_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR_BEST,
		OP_CAP_I,
		OP_CAP_J,
		OP_DIFF,
		OP_MUL,
		OP_MUL_STORE,
		OP_SUM_C,
		OP_SUM_A,
		OP_SUM_B,
		OP_DISC,
		OP_SQRT,
		OP_DEN,
		OP_DIV,
		OP_TAKE,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		MS_DXDX,
		MS_DYDY,
		MS_RSRS,
		MS_VXVX,
		MS_VYVY,
		MS_DXVX,
		MS_DYVY,
		MS_BB,
		MS_AC
	} msel_t;

	typedef struct packed {
		op_t op;
		msel_t msel;
		logic [IDX_W-1:0] first_idx;
		logic [IDX_W-1:0] second_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic both_static;
		logic overlap;
		logic a_zero;
		logic separating;
		logic disc_neg;
		logic saturated;
		logic busy;
		logic better;
	} dp_stat_t;

endpackage

FILE: rtl/ecis_circle_if.sv
// Circle input channel: valid/ready handshake plus one circle's fields.
// No dependencies.
interface ecis_circle_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic [30:0] radius;
	logic is_static;
	logic last_circle;

	modport source(output valid, pos_x, pos_y, vel_x, vel_y, radius, is_static, last_circle,
		input ready);
	modport sink(input valid, pos_x, pos_y, vel_x, vel_y, radius, is_static, last_circle,
		output ready);
endinterface

FILE: rtl/ecis_result_if.sv
// Result channel: valid/ready handshake plus found flag, time and pair indices.
// No dependencies.
interface ecis_result_if;
	logic valid;
	logic ready;
	logic found;
	logic [31:0] impact_time;
	logic [5:0] first_index;
	logic [5:0] second_index;

	modport source(output valid, found, impact_time, first_index, second_index, input ready);
	modport sink(input valid, found, impact_time, first_index, second_index, output ready);
endinterface

FILE: rtl/ecis_cfg_if.sv
// Configuration write channel: valid/ready handshake plus max_time data.
// No dependencies.
interface ecis_cfg_if;
	logic valid;
	logic ready;
	logic [31:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

FILE: rtl/ecis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ecis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/ecis_ctrl.sv
// Controller: circle loading, pair enumeration and per-pair command sequencing.
// Depends on ecis_pkg.
module ecis_ctrl #(
	parameter int MAX_CIRCLES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_last,
	output logic in_ready,
	input logic out_ready,
	output logic out_valid,
	output logic ram_we,
	output logic [$clog2(MAX_CIRCLES)-1:0] ram_waddr,
	output logic [$clog2(MAX_CIRCLES)-1:0] ram_raddr,
	output ecis_pkg::dp_cmd_t cmd,
	input ecis_pkg::dp_stat_t stat
);
	import ecis_pkg::*;

	localparam int AW = $clog2(MAX_CIRCLES);
	localparam int CW = $clog2(MAX_CIRCLES + 1);

	typedef enum logic [4:0] {
		S_LOAD, S_RD_I, S_RD_J, S_CAP_J, S_DIFF, S_MUL_GO, S_MUL_WAIT,
		S_CHK_C, S_CHK_A, S_CHK_B, S_CHK_S, S_DISC, S_DISC_CHK,
		S_SQRT_WAIT, S_DEN_CHK, S_DIV_WAIT, S_TAKE, S_NEXT, S_EMIT
	} state_t;

	state_t state_q, state_d;
	msel_t msel_q, msel_d;
	logic [CW-1:0] count_q, n_q, i_q, j_q;
	logic [CW-1:0] count_nx;
	logic [CW:0] j_inc, i_inc2;
	logic [CW+IDX_W-1:0] ext_i, ext_j;
	logic accept, not_full, pair_done, emit;

	assign in_ready = (state_q == S_LOAD);
	assign accept = in_valid && in_ready;
	assign not_full = (count_q < CW'(MAX_CIRCLES));
	assign count_nx = not_full ? count_q + CW'(1) : count_q;
	assign ram_we = accept && not_full;
	assign ram_waddr = count_q[AW-1:0];
	assign ram_raddr = (state_q == S_RD_J) ? j_q[AW-1:0] : i_q[AW-1:0];
	assign j_inc = {1'b0, j_q} + (CW+1)'(1);
	assign i_inc2 = {1'b0, i_q} + (CW+1)'(2);
	assign pair_done = (j_inc >= {1'b0, n_q}) && (i_inc2 >= {1'b0, n_q});
	assign ext_i = {{IDX_W{1'b0}}, i_q};
	assign ext_j = {{IDX_W{1'b0}}, j_q};
	assign emit = (state_q == S_EMIT) && (!out_valid || out_ready);

	always_comb begin
		state_d = state_q;
		msel_d = msel_q;
		cmd.op = OP_NONE;
		cmd.msel = msel_q;
		// indices of the pair are masked to the result field width
		cmd.first_idx = ext_i[IDX_W-1:0];
		cmd.second_idx = ext_j[IDX_W-1:0];
		case (state_q)
			S_LOAD: begin
				if (accept && in_last) begin
					cmd.op = OP_CLEAR_BEST;
					state_d = (count_nx >= CW'(2)) ? S_RD_I : S_EMIT;
				end
			end
			S_RD_I: state_d = S_RD_J;
			S_RD_J: begin
				cmd.op = OP_CAP_I;
				state_d = S_CAP_J;
			end
			S_CAP_J: begin
				cmd.op = OP_CAP_J;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				if (stat.both_static) begin
					state_d = S_NEXT;
				end else begin
					cmd.op = OP_DIFF;
					msel_d = MS_DXDX;
					state_d = S_MUL_GO;
				end
			end
			S_MUL_GO: begin
				cmd.op = OP_MUL;
				state_d = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (!stat.busy) begin
					cmd.op = OP_MUL_STORE;
					state_d = S_MUL_GO;
					case (msel_q)
						MS_DXDX: msel_d = MS_DYDY;
						MS_DYDY: msel_d = MS_RSRS;
						MS_RSRS: msel_d = MS_VXVX;
						MS_VXVX: msel_d = MS_VYVY;
						MS_VYVY: msel_d = MS_DXVX;
						MS_DXVX: msel_d = MS_DYVY;
						MS_DYVY: state_d = S_CHK_C;
						MS_BB: msel_d = MS_AC;
						default: state_d = S_DISC;
					endcase
				end
			end
			S_CHK_C: begin
				cmd.op = OP_SUM_C;
				state_d = S_CHK_A;
			end
			S_CHK_A: begin
				if (stat.overlap) begin
					state_d = S_NEXT;
				end else begin
					cmd.op = OP_SUM_A;
					state_d = S_CHK_B;
				end
			end
			S_CHK_B: begin
				if (stat.a_zero) begin
					state_d = S_NEXT;
				end else begin
					cmd.op = OP_SUM_B;
					state_d = S_CHK_S;
				end
			end
			S_CHK_S: begin
				if (stat.separating) begin
					state_d = S_NEXT;
				end else begin
					msel_d = MS_BB;
					state_d = S_MUL_GO;
				end
			end
			S_DISC: begin
				cmd.op = OP_DISC;
				state_d = S_DISC_CHK;
			end
			S_DISC_CHK: begin
				if (stat.disc_neg) begin
					state_d = S_NEXT;
				end else begin
					cmd.op = OP_SQRT;
					state_d = S_SQRT_WAIT;
				end
			end
			S_SQRT_WAIT: begin
				if (!stat.busy) begin
					cmd.op = OP_DEN;
					state_d = S_DEN_CHK;
				end
			end
			S_DEN_CHK: begin
				if (stat.saturated) begin
					state_d = S_TAKE;
				end else begin
					cmd.op = OP_DIV;
					state_d = S_DIV_WAIT;
				end
			end
			S_DIV_WAIT: begin
				if (!stat.busy) begin
					state_d = S_TAKE;
				end
			end
			S_TAKE: begin
				cmd.op = OP_TAKE;
				state_d = S_NEXT;
			end
			S_NEXT: state_d = pair_done ? S_EMIT : S_RD_I;
			S_EMIT: begin
				if (emit) begin
					cmd.op = OP_EMIT;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			msel_q <= MS_DXDX;
			count_q <= '0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			msel_q <= msel_d;
			if (accept) begin
				if (in_last) begin
					n_q <= count_nx;
					count_q <= '0;
					i_q <= '0;
					j_q <= CW'(1);
				end else begin
					count_q <= count_nx;
				end
			end
			if (state_q == S_NEXT && !pair_done) begin
				if (j_inc < {1'b0, n_q}) begin
					j_q <= j_inc[CW-1:0];
				end else begin
					i_q <= i_q + CW'(1);
					j_q <= i_inc2[CW-1:0];
				end
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_CIRCLES))
		else $error("load count beyond store depth");
	a_last_stops_load: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |=> !in_ready)
		else $error("input still taken after last circle");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIFF) |-> (j_q > i_q && j_q < n_q))
		else $error("pair indices out of order");
	a_units_idle_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> !stat.busy)
		else $error("arithmetic unit busy while loading");
endmodule

FILE: rtl/ecis_dpath.sv
// Datapath: pair differences, shift-add multiplier, digit-by-digit square root,
// restoring divider, best-pair tracking and result register. Depends on ecis_pkg.
module ecis_dpath (
	input logic clk,
	input logic arst_n,
	input ecis_pkg::dp_cmd_t cmd,
	output ecis_pkg::dp_stat_t stat,
	input ecis_pkg::circle_t rd_circle,
	input logic cfg_we,
	input logic [31:0] cfg_data,
	output logic res_found,
	output logic [31:0] res_time,
	output logic [ecis_pkg::IDX_W-1:0] res_first,
	output logic [ecis_pkg::IDX_W-1:0] res_second
);
	import ecis_pkg::*;

	circle_t cir_i_q, cir_j_q;
	logic [MAG_W-1:0] dx_q, dy_q, vx_q, vy_q;
	logic dx_neg_q, dy_neg_q, vx_neg_q, vy_neg_q;
	logic [31:0] rs_q;
	logic [PW-1:0] acc_q, a_sh_q;
	logic [MW-1:0] b_q;
	logic [65:0] sq_dx_q, sq_dy_q, sq_vx_q, sq_vy_q, pr_x_q, pr_y_q;
	logic [63:0] sq_rs_q;
	logic [PW-1:0] bb_q, ac_q, disc_q;
	logic [MW-1:0] c_q, a_q, bneg_q, root_q;
	logic overlap_q, sep_q, disc_neg_q, sat_q;
	logic [MW+2:0] srem_q;
	logic [6:0] scnt_q;
	logic [MW:0] den_q;
	logic [MW+15:0] drem_q;
	logic [MW+31:0] dsh_q;
	logic [5:0] dcnt_q;
	logic [31:0] q_q, max_time_q, best_time_q;
	logic best_valid_q;
	logic [IDX_W-1:0] best_first_q, best_second_q;

	logic [MAG_W:0] dfx, dfy, dvx, dvy;
	logic [MW-1:0] ma, mb, dist2, pos_sum, neg_sum;
	logic [MW:0] cdiff, bdiff, den_w;
	logic [PW:0] ddiff;
	logic [MW+2:0] srem_sh, trial;
	logic s_ge, d_ge, xneg, yneg;

	function automatic logic [MAG_W:0] sm_diff(logic [31:0] a, logic [31:0] b);
		logic [MAG_W-1:0] d;
		d = {a[31], a} - {b[31], b};
		return {d[MAG_W-1], d[MAG_W-1] ? (~d + MAG_W'(1)) : d};
	endfunction

	assign dfx = sm_diff(cir_j_q.pos_x, cir_i_q.pos_x);
	assign dfy = sm_diff(cir_j_q.pos_y, cir_i_q.pos_y);
	assign dvx = sm_diff(cir_j_q.vel_x, cir_i_q.vel_x);
	assign dvy = sm_diff(cir_j_q.vel_y, cir_i_q.vel_y);

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.msel)
			MS_DXDX: begin ma = MW'(dx_q); mb = MW'(dx_q); end
			MS_DYDY: begin ma = MW'(dy_q); mb = MW'(dy_q); end
			MS_RSRS: begin ma = MW'(rs_q); mb = MW'(rs_q); end
			MS_VXVX: begin ma = MW'(vx_q); mb = MW'(vx_q); end
			MS_VYVY: begin ma = MW'(vy_q); mb = MW'(vy_q); end
			MS_DXVX: begin ma = MW'(dx_q); mb = MW'(vx_q); end
			MS_DYVY: begin ma = MW'(dy_q); mb = MW'(vy_q); end
			MS_BB: begin ma = bneg_q; mb = bneg_q; end
			MS_AC: begin ma = a_q; mb = c_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign dist2 = {1'b0, sq_dx_q} + {1'b0, sq_dy_q};
	assign cdiff = {1'b0, dist2} - (MW+1)'(sq_rs_q);
	assign xneg = dx_neg_q ^ vx_neg_q;
	assign yneg = dy_neg_q ^ vy_neg_q;
	assign pos_sum = (xneg ? MW'(0) : MW'(pr_x_q)) + (yneg ? MW'(0) : MW'(pr_y_q));
	assign neg_sum = (xneg ? MW'(pr_x_q) : MW'(0)) + (yneg ? MW'(pr_y_q) : MW'(0));
	assign bdiff = {1'b0, neg_sum} - {1'b0, pos_sum};
	assign ddiff = {1'b0, bb_q} - {1'b0, ac_q};
	assign srem_sh = {srem_q[MW:0], disc_q[PW-1:PW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign s_ge = (srem_sh >= trial);
	assign den_w = {1'b0, bneg_q} + {1'b0, root_q};
	assign d_ge = ({16'b0, drem_q} >= dsh_q);

	assign stat.both_static = cir_i_q.is_static & cir_j_q.is_static;
	assign stat.overlap = overlap_q;
	assign stat.a_zero = (a_q == '0);
	assign stat.separating = sep_q;
	assign stat.disc_neg = disc_neg_q;
	assign stat.saturated = sat_q;
	assign stat.busy = (b_q != '0) || (scnt_q != '0) || (dcnt_q != '0);
	assign stat.better = (q_q <= max_time_q) && (!best_valid_q || q_q < best_time_q);

	// control state of the iterative units, best pair and max_time register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
			scnt_q <= '0;
			dcnt_q <= '0;
			max_time_q <= MAX_TIME_RST;
			best_valid_q <= 1'b0;
			best_time_q <= '0;
			best_first_q <= '0;
			best_second_q <= '0;
		end else begin
			if (cfg_we) begin
				max_time_q <= cfg_data;
			end
			if (cmd.op == OP_MUL) begin
				b_q <= mb;
			end else if (b_q != '0) begin
				b_q <= b_q >> 1;
			end
			if (cmd.op == OP_SQRT) begin
				scnt_q <= 7'(PW / 2);
			end else if (scnt_q != '0) begin
				scnt_q <= scnt_q - 7'd1;
			end
			if (cmd.op == OP_DIV) begin
				dcnt_q <= 6'd32;
			end else if (dcnt_q != '0) begin
				dcnt_q <= dcnt_q - 6'd1;
			end
			if (cmd.op == OP_CLEAR_BEST) begin
				best_valid_q <= 1'b0;
				best_time_q <= '0;
				best_first_q <= '0;
				best_second_q <= '0;
			end else if (cmd.op == OP_TAKE && stat.better) begin
				best_valid_q <= 1'b1;
				best_time_q <= q_q;
				best_first_q <= cmd.first_idx;
				best_second_q <= cmd.second_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_MUL) begin
			acc_q <= '0;
			a_sh_q <= PW'(ma);
		end else if (b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_sh_q;
			end
			a_sh_q <= a_sh_q << 1;
		end
		if (scnt_q != '0) begin
			disc_q <= disc_q << 2;
			srem_q <= s_ge ? (srem_sh - trial) : srem_sh;
			root_q <= {root_q[MW-2:0], s_ge};
		end
		if (dcnt_q != '0) begin
			if (d_ge) begin
				drem_q <= drem_q - dsh_q[MW+15:0];
			end
			q_q <= {q_q[30:0], d_ge};
			dsh_q <= dsh_q >> 1;
		end
		case (cmd.op)
			OP_CAP_I: cir_i_q <= rd_circle;
			OP_CAP_J: cir_j_q <= rd_circle;
			OP_DIFF: begin
				{dx_neg_q, dx_q} <= dfx;
				{dy_neg_q, dy_q} <= dfy;
				{vx_neg_q, vx_q} <= dvx;
				{vy_neg_q, vy_q} <= dvy;
				rs_q <= {1'b0, cir_i_q.radius} + {1'b0, cir_j_q.radius};
			end
			OP_MUL_STORE: begin
				case (cmd.msel)
					MS_DXDX: sq_dx_q <= acc_q[65:0];
					MS_DYDY: sq_dy_q <= acc_q[65:0];
					MS_RSRS: sq_rs_q <= acc_q[63:0];
					MS_VXVX: sq_vx_q <= acc_q[65:0];
					MS_VYVY: sq_vy_q <= acc_q[65:0];
					MS_DXVX: pr_x_q <= acc_q[65:0];
					MS_DYVY: pr_y_q <= acc_q[65:0];
					MS_BB: bb_q <= acc_q;
					default: ac_q <= acc_q;
				endcase
			end
			OP_SUM_C: begin
				c_q <= cdiff[MW-1:0];
				overlap_q <= cdiff[MW];
			end
			OP_SUM_A: a_q <= {1'b0, sq_vx_q} + {1'b0, sq_vy_q};
			OP_SUM_B: begin
				bneg_q <= bdiff[MW-1:0];
				sep_q <= bdiff[MW] || (bdiff == '0);
			end
			OP_DISC: begin
				disc_q <= ddiff[PW-1:0];
				disc_neg_q <= ddiff[PW];
			end
			OP_SQRT: begin
				srem_q <= '0;
				root_q <= '0;
			end
			OP_DEN: begin
				den_q <= den_w;
				// quotient would need more than 32 bits: saturate
				sat_q <= ({17'b0, c_q} >= {den_w, 16'b0});
				q_q <= '1;
			end
			OP_DIV: begin
				drem_q <= {c_q, 16'b0};
				dsh_q <= {den_q, 31'b0};
				q_q <= '0;
			end
			OP_EMIT: begin
				res_found <= best_valid_q;
				res_time <= best_time_q;
				res_first <= best_first_q;
				res_second <= best_second_q;
			end
			default: ;
		endcase
	end
endmodule

FILE: rtl/earliest_circle_impact_search_core.sv
// Earliest circle impact search, top level. One circle loads per cycle while
// the core is loading; input is held off during the pair search after the last
// circle. Each pair i<j is skipped early if both are static; otherwise it can
// run through the shift-add multiplier (one multiplier bit a cycle, 9 products),
// the 67-step square root and the 32-step divider. Then the result is registered.
// Reset (arst_n low): control cleared, max_time = 1.0; store is not cleared.
module earliest_circle_impact_search_core #(
	parameter int MAX_CIRCLES = ecis_pkg::MAX_CIRCLES_DEF
) (
	input logic clk,
	input logic arst_n,
	ecis_circle_if.sink circles,
	ecis_result_if.source result,
	ecis_cfg_if.sink cfg
);
	import ecis_pkg::*;

	localparam int AW = $clog2(MAX_CIRCLES);

	dp_cmd_t cmd;
	dp_stat_t stat;
	circle_t wr_circle, rd_circle;
	logic [$bits(circle_t)-1:0] rd_word;
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;

	// config writes are always taken; software writes only while idle
	assign cfg.ready = 1'b1;

	// pack the incoming circle into one store word
	assign wr_circle.pos_x = circles.pos_x;
	assign wr_circle.pos_y = circles.pos_y;
	assign wr_circle.vel_x = circles.vel_x;
	assign wr_circle.vel_y = circles.vel_y;
	assign wr_circle.radius = circles.radius;
	assign wr_circle.is_static = circles.is_static;
	assign rd_circle = circle_t'(rd_word);

	// circle store: one write port for loading, one read port for the pair search
	ecis_ram #(
		.WIDTH($bits(circle_t)),
		.DEPTH(MAX_CIRCLES)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(wr_circle),
		.raddr(ram_raddr),
		.rdata(rd_word)
	);

	// sequencer: loading, pair walk, per-pair steps, result hand-off
	ecis_ctrl #(
		.MAX_CIRCLES(MAX_CIRCLES)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(circles.valid),
		.in_last(circles.last_circle),
		.in_ready(circles.ready),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_raddr(ram_raddr),
		.cmd(cmd),
		.stat(stat)
	);

	// arithmetic and the result register
	ecis_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.rd_circle(rd_circle),
		.cfg_we(cfg.valid),
		.cfg_data(cfg.data),
		.res_found(result.found),
		.res_time(result.impact_time),
		.res_first(result.first_index),
		.res_second(result.second_index)
	);
endmodule
